// File: src/pbfa_pkg.sv
// ----------------------------------------------------------------------------
// pbfa_pkg
// Shared types and constants for the packed bit-field access block.
// ----------------------------------------------------------------------------
package pbfa_pkg;

  // Fixed geometry of the store word and of the command fields.
  localparam int WORD_BITS  = 64;
  localparam int OFF_W      = 6;
  localparam int INDEX_W    = 16;
  localparam int LEN_W      = 7;
  localparam int WIDX_W     = INDEX_W - OFF_W;

  // Command codes.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_PAST_END = 2'd2
  } status_t;

  // One classified command as it waits between the front and back parts.
  typedef struct packed {
    logic                 cmd;
    status_t              status;
    logic [WIDX_W-1:0]    widx;
    logic [OFF_W-1:0]     off;
    logic                 straddle;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] val;
  } cmd_entry_t;

  // Back part sequencer states.
  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RD_LO,
    BK_RD_HI,
    BK_WR_HI,
    BK_DONE
  } back_state_t;

endpackage

// File: src/pbfa_front.sv
// ----------------------------------------------------------------------------
// pbfa_front
// Classifies an incoming word: checks the length and the store bounds,
// splits the bit index and builds the field mask and masked write value.
// ----------------------------------------------------------------------------
module pbfa_front #(
  parameter int STORE_WORDS = 1024
) (
  input  logic                           cmd,
  input  logic [pbfa_pkg::INDEX_W-1:0]   bit_index,
  input  logic [pbfa_pkg::LEN_W-1:0]     field_length,
  input  logic [pbfa_pkg::WORD_BITS-1:0] write_value,
  output pbfa_pkg::cmd_entry_t           entry
);

  localparam logic [31:0] TOTAL_BITS = 32'(STORE_WORDS) * 32'(pbfa_pkg::WORD_BITS);

  logic [pbfa_pkg::INDEX_W:0]     end_bit;
  logic [7:0]                     off_end;
  logic                           bad_len;
  logic                           past_end;
  logic [pbfa_pkg::WORD_BITS-1:0] mask;

  // Bounds and length checks; the length check takes priority.
  always_comb begin
    end_bit  = {1'b0, bit_index} + (pbfa_pkg::INDEX_W + 1)'(field_length);
    bad_len  = (field_length == '0) ||
               (field_length > pbfa_pkg::LEN_W'(pbfa_pkg::WORD_BITS));
    past_end = 32'(end_bit) > TOTAL_BITS;
    off_end  = 8'(bit_index[pbfa_pkg::OFF_W-1:0]) + 8'(field_length);
    if (field_length >= pbfa_pkg::LEN_W'(pbfa_pkg::WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = (pbfa_pkg::WORD_BITS'(1) << field_length) - pbfa_pkg::WORD_BITS'(1);
    end
  end

  // Pack the classified command.
  always_comb begin
    entry.cmd      = cmd;
    if (bad_len) begin
      entry.status = pbfa_pkg::ST_BAD_LEN;
    end else if (past_end) begin
      entry.status = pbfa_pkg::ST_PAST_END;
    end else begin
      entry.status = pbfa_pkg::ST_OK;
    end
    entry.widx     = bit_index[pbfa_pkg::INDEX_W-1:pbfa_pkg::OFF_W];
    entry.off      = bit_index[pbfa_pkg::OFF_W-1:0];
    entry.straddle = off_end > 8'(pbfa_pkg::WORD_BITS);
    entry.mask     = mask;
    entry.val      = write_value & mask;
  end

endmodule

// File: src/pbfa_queue.sv
// ----------------------------------------------------------------------------
// pbfa_queue
// Two-entry queue of classified commands between the front and back parts.
// ----------------------------------------------------------------------------
module pbfa_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pbfa_pkg::cmd_entry_t push_entry,
  input  logic                 pop,
  output pbfa_pkg::cmd_entry_t head,
  output logic                 not_empty,
  output logic                 full
);

  pbfa_pkg::cmd_entry_t ent_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;

  assign head      = ent_r[rd_ptr_r];
  assign not_empty = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: src/pbfa_back.sv
// ----------------------------------------------------------------------------
// pbfa_back
// Carries out classified commands on the single-port word store and holds
// the result word until the output side takes it. Clears the store after
// reset.
// ----------------------------------------------------------------------------
module pbfa_back #(
  parameter int STORE_WORDS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pbfa_pkg::cmd_entry_t           head,
  input  logic                           head_valid,
  output logic                           pop,
  output logic                           clearing,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pbfa_pkg::WORD_BITS-1:0] out_read_data,
  output logic [1:0]                     out_status
);

  localparam int ADDR_W  = $clog2(STORE_WORDS);
  localparam int W       = pbfa_pkg::WORD_BITS;
  localparam int OFF_W_L = pbfa_pkg::OFF_W;

  pbfa_pkg::back_state_t state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  pbfa_pkg::cmd_entry_t  cur_r, cur_nxt;
  logic [W-1:0]          lo_r, lo_nxt;
  logic [W-1:0]          hi_r, hi_nxt;
  logic [W-1:0]          res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [W-1:0]          out_data_r, out_data_nxt;
  logic [1:0]            out_status_r, out_status_nxt;

  logic [W-1:0]          mem [STORE_WORDS];
  logic [W-1:0]          rdata_r;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [W-1:0]          mem_wdata;

  logic [ADDR_W-1:0]     addr_lo;
  logic [ADDR_W-1:0]     addr_hi;
  logic [OFF_W_L-1:0]    hi_sh;
  logic [2*W-1:0]        pair_lo;
  logic [2*W-1:0]        pair_hi;
  logic [W-1:0]          merge_lo_rd;
  logic [W-1:0]          merge_lo_held;
  logic [W-1:0]          merge_hi;

  assign clearing      = state_r == pbfa_pkg::BK_CLEAR;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_status    = out_status_r;

  // Word addresses of the two words a field may touch.
  assign addr_lo = ADDR_W'(cur_r.widx);
  assign addr_hi = ADDR_W'(cur_r.widx) + ADDR_W'(1);
  assign hi_sh   = OFF_W_L'(0) - cur_r.off;

  // Field extraction and merging.
  always_comb begin
    pair_lo       = {{W{1'b0}}, rdata_r} >> cur_r.off;
    pair_hi       = {rdata_r, lo_r} >> cur_r.off;
    merge_lo_rd   = (rdata_r & ~(cur_r.mask << cur_r.off)) | (cur_r.val << cur_r.off);
    merge_lo_held = (lo_r & ~(cur_r.mask << cur_r.off)) | (cur_r.val << cur_r.off);
    merge_hi      = (hi_r & ~(cur_r.mask >> hi_sh)) | (cur_r.val >> hi_sh);
  end

  // Sequencer: next state, memory port and result.
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_nxt        = cur_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    res_nxt        = res_r;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = addr_lo;
    mem_wdata      = merge_lo_rd;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      pbfa_pkg::BK_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(STORE_WORDS - 1)) begin
          state_nxt = pbfa_pkg::BK_IDLE;
        end
      end
      pbfa_pkg::BK_IDLE: begin
        mem_addr = ADDR_W'(head.widx);
        if (head_valid) begin
          pop     = 1'b1;
          cur_nxt = head;
          res_nxt = '0;
          if (head.status == pbfa_pkg::ST_OK) begin
            state_nxt = pbfa_pkg::BK_RD_LO;
          end else begin
            state_nxt = pbfa_pkg::BK_DONE;
          end
        end
      end
      pbfa_pkg::BK_RD_LO: begin
        // The low word has arrived.
        if (cur_r.straddle) begin
          lo_nxt    = rdata_r;
          mem_addr  = addr_hi;
          state_nxt = pbfa_pkg::BK_RD_HI;
        end else if (cur_r.cmd == pbfa_pkg::CMD_READ) begin
          res_nxt   = pair_lo[W-1:0] & cur_r.mask;
          state_nxt = pbfa_pkg::BK_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = merge_lo_rd;
          state_nxt = pbfa_pkg::BK_DONE;
        end
      end
      pbfa_pkg::BK_RD_HI: begin
        // The high word has arrived.
        if (cur_r.cmd == pbfa_pkg::CMD_READ) begin
          res_nxt   = pair_hi[W-1:0] & cur_r.mask;
          state_nxt = pbfa_pkg::BK_DONE;
        end else begin
          hi_nxt    = rdata_r;
          mem_we    = 1'b1;
          mem_wdata = merge_lo_held;
          state_nxt = pbfa_pkg::BK_WR_HI;
        end
      end
      pbfa_pkg::BK_WR_HI: begin
        mem_we    = 1'b1;
        mem_addr  = addr_hi;
        mem_wdata = merge_hi;
        state_nxt = pbfa_pkg::BK_DONE;
      end
      pbfa_pkg::BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_r;
          out_status_nxt = cur_r.status;
          state_nxt      = pbfa_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = pbfa_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbfa_pkg::BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  // Single-port word store, read-first, with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

endmodule

// File: src/packed_bit_field_access.sv
// ----------------------------------------------------------------------------
// packed_bit_field_access
// Bit-addressed store of 64-bit words with field read and write commands.
// ----------------------------------------------------------------------------
// Each command reads or writes a field of 1 to 64 bits starting at any bit
// index, and a field may straddle two words. Every command gives exactly
// one result word: the right-aligned field on a read, zero on a write, with
// a status of ok, invalid length or field past the end of the store. All
// store words go through one single-port memory with a registered read, so
// a field inside one word is read and, on a write, written back; a read that
// straddles two words fetches the low and then the high word, and a straddling
// write fetches both and then writes back the low and then the high word. A
// rejected command goes straight to its result. After reset the store is
// cleared one word per cycle, and in_stall stays high until that pass is done.
// A two-entry queue lets new commands in while a result waits on out_stall.
// ----------------------------------------------------------------------------
module packed_bit_field_access #(
  parameter int STORE_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_bit_index,
  input  logic [6:0]  in_field_length,
  input  logic [63:0] in_write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_read_data,
  output logic [1:0]  out_status
);

  pbfa_pkg::cmd_entry_t new_entry;
  pbfa_pkg::cmd_entry_t head;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_not_empty;
  logic                 q_full;
  logic                 clearing;

  // Input side stalls while the queue is full or the store is being cleared.
  assign in_stall = q_full || clearing;
  assign q_push   = in_valid && !in_stall;

  pbfa_front #(
    .STORE_WORDS (STORE_WORDS)
  ) u_front (
    .cmd          (in_cmd),
    .bit_index    (in_bit_index),
    .field_length (in_field_length),
    .write_value  (in_write_value),
    .entry        (new_entry)
  );

  pbfa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (new_entry),
    .pop        (q_pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  pbfa_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .head_valid    (q_not_empty),
    .pop           (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_status    (out_status)
  );

endmodule

// File: verif/packed_bit_field_access_test.sv
// ----------------------------------------------------------------------------
// packed_bit_field_access_test
// Self-checking bench for the packed bit-field access block.
// ----------------------------------------------------------------------------
// A short directed list comes first. It covers full-width and single-bit
// fields, fields that straddle two words, bad lengths, and fields at and past
// the end of the store. A random mix of reads and writes follows. Most
// accesses land in a few words at the bottom and top of the store, so reads
// see earlier writes, and many writes are read back at once. A checker class
// keeps a private copy of the store and predicts every result word. Both
// sides idle at random.
// ----------------------------------------------------------------------------
module packed_bit_field_access_test;

  localparam int STORE_WORDS  = 1024;
  localparam int STORE_BITS   = STORE_WORDS * pbfa_pkg::WORD_BITS;
  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    logic [63:0]       read_data;
    pbfa_pkg::status_t status;
  } field_result_t;

  // Private copy of the store, plus the queue of result words still owed.
  class field_access_checker;
    logic [63:0]   words [STORE_WORDS];
    field_result_t owed_results [$];
    int            failures;

    function new();
      foreach (words[i]) words[i] = '0;
      failures = 0;
    endfunction

    // Work out the result of an accepted command word and apply any write.
    function void note_command(logic c, logic [15:0] idx, logic [6:0] len,
                               logic [63:0] val);
      field_result_t r;
      logic [63:0]   mask;
      logic [127:0]  pair;
      logic [127:0]  pair_mask;
      int            widx;
      int            off;
      r.read_data = '0;
      r.status    = pbfa_pkg::ST_OK;
      if (len == 0 || len > pbfa_pkg::WORD_BITS) begin
        r.status = pbfa_pkg::ST_BAD_LEN;
      end else if (int'(idx) + int'(len) > STORE_BITS) begin
        r.status = pbfa_pkg::ST_PAST_END;
      end else begin
        widx = int'(idx) / pbfa_pkg::WORD_BITS;
        off  = int'(idx) % pbfa_pkg::WORD_BITS;
        mask = (len == pbfa_pkg::WORD_BITS) ? '1 : ((64'd1 << len) - 64'd1);
        // Treat the word and its upper neighbor as one 128-bit window.
        pair[63:0]   = words[widx];
        pair[127:64] = (widx < STORE_WORDS - 1) ? words[widx + 1] : '0;
        if (c == pbfa_pkg::CMD_READ) begin
          r.read_data = 64'(pair >> off) & mask;
        end else begin
          pair_mask = {64'd0, mask} << off;
          pair = (pair & ~pair_mask) | ({64'd0, val & mask} << off);
          words[widx] = pair[63:0];
          if (widx < STORE_WORDS - 1) words[widx + 1] = pair[127:64];
        end
      end
      owed_results.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_result(logic [63:0] data, logic [1:0] status);
      field_result_t e;
      if (owed_results.size() == 0) begin
        $error("result word with no command outstanding: read_data %h status %0d",
               data, status);
        failures++;
        return;
      end
      e = owed_results.pop_front();
      if (data !== e.read_data) begin
        $error("read_data mismatch: expected %h, got %h", e.read_data, data);
        failures++;
      end
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, got %0d", e.status, status);
        failures++;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [15:0] in_bit_index;
  logic [6:0]  in_field_length;
  logic [63:0] in_write_value;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_read_data;
  logic [1:0]  out_status;

  field_access_checker store_model;
  int                  sender_calm;

  packed_bit_field_access #(
    .STORE_WORDS(STORE_WORDS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_bit_index    (in_bit_index),
    .in_field_length (in_field_length),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

  // Every result word taken at a rising edge goes to the checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) store_model.check_result(out_read_data, out_status);
  end

  // Receiver back-pressure: short and long stall bursts, with calm stretches.
  initial begin
    int hold;
    int calm;
    int pick;
    hold = 0;
    calm = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (calm > 0) begin
        calm--;
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        pick = $urandom_range(99);
        if (pick < 3) hold = $urandom_range(60, 20);
        else if (pick < 30) hold = $urandom_range(3, 1);
        else if (pick < 36) calm = $urandom_range(80, 20);
      end
    end
  end

  // Offer one command word, starting and ending at a falling edge.
  task automatic send_command(input logic c, input logic [15:0] idx,
                              input logic [6:0] len, input logic [63:0] val);
    int gap;
    int pick;
    gap = 0;
    if (sender_calm > 0) begin
      sender_calm--;
    end else begin
      pick = $urandom_range(99);
      if (pick < 3) gap = $urandom_range(60, 20);
      else if (pick < 35) gap = $urandom_range(3, 1);
      else if (pick < 40) sender_calm = $urandom_range(60, 20);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= c;
    in_bit_index    <= idx;
    in_field_length <= len;
    in_write_value  <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    store_model.note_command(c, idx, len, val);
    @(negedge clk);
  endtask

  task automatic run_directed();
    // Empty store, then a full-width write of all ones and its read-back.
    send_command(pbfa_pkg::CMD_READ,  16'd0,   7'd64, 64'h0);
    send_command(pbfa_pkg::CMD_WRITE, 16'd0,   7'd64, '1);
    send_command(pbfa_pkg::CMD_READ,  16'd0,   7'd64, 64'h0);
    // Straddling write in the middle of a word pair, read back from both sides.
    send_command(pbfa_pkg::CMD_WRITE, 16'd100, 7'd64, 64'h0123_4567_89AB_CDEF);
    send_command(pbfa_pkg::CMD_READ,  16'd100, 7'd64, 64'h0);
    send_command(pbfa_pkg::CMD_READ,  16'd96,  7'd64, 64'h0);
    // Field starting at the top bit of a word.
    send_command(pbfa_pkg::CMD_WRITE, 16'd127, 7'd64, 64'hFFFF_0000_FFFF_0000);
    send_command(pbfa_pkg::CMD_READ,  16'd64,  7'd64, 64'h0);
    send_command(pbfa_pkg::CMD_READ,  16'd128, 7'd64, 64'h0);
    // Single-bit set and clear; only the low bit of the value counts.
    send_command(pbfa_pkg::CMD_WRITE, 16'd200, 7'd1,  64'h1);
    send_command(pbfa_pkg::CMD_READ,  16'd200, 7'd1,  64'h0);
    send_command(pbfa_pkg::CMD_WRITE, 16'd200, 7'd1,  64'hFFFF_FFFF_FFFF_FFFE);
    send_command(pbfa_pkg::CMD_READ,  16'd192, 7'd16, 64'h0);
    // Bad lengths on both commands; the store must not change.
    send_command(pbfa_pkg::CMD_WRITE, 16'd0,   7'd0,  64'h0);
    send_command(pbfa_pkg::CMD_WRITE, 16'd0,   7'd65, 64'h0);
    send_command(pbfa_pkg::CMD_READ,  16'd0,   7'd127, 64'h0);
    send_command(pbfa_pkg::CMD_READ,  16'd0,   7'd64, 64'h0);
    // Last bit of the store, then fields running past the end.
    send_command(pbfa_pkg::CMD_WRITE, 16'd65535, 7'd1,  64'h1);
    send_command(pbfa_pkg::CMD_READ,  16'd65535, 7'd1,  64'h0);
    send_command(pbfa_pkg::CMD_READ,  16'd65535, 7'd2,  64'h0);
    send_command(pbfa_pkg::CMD_WRITE, 16'd65500, 7'd64, '1);
    send_command(pbfa_pkg::CMD_READ,  16'd65472, 7'd64, 64'h0);
    send_command(pbfa_pkg::CMD_WRITE, 16'd65472, 7'd64, 64'h5A5A_A5A5_3C3C_C3C3);
    send_command(pbfa_pkg::CMD_READ,  16'd65472, 7'd64, 64'h0);
  endtask

  task automatic run_random();
    int          sent;
    int          pick;
    logic        c;
    logic [15:0] idx;
    logic [6:0]  len;
    logic [63:0] val;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // Bias addresses toward a few words so reads see earlier writes.
      pick = $urandom_range(99);
      if (pick < 45) idx = 16'($urandom_range(511));
      else if (pick < 70) idx = 16'(STORE_BITS - 512 + $urandom_range(511));
      else if (pick < 88) idx = 16'($urandom_range(65535));
      else idx = 16'($urandom_range(STORE_WORDS - 1) * pbfa_pkg::WORD_BITS
                     + pbfa_pkg::WORD_BITS - $urandom_range(3, 1));
      pick = $urandom_range(99);
      if (pick < 4) len = 7'd0;
      else if (pick < 9) len = 7'($urandom_range(127, 65));
      else if (pick < 22) len = 7'd64;
      else len = 7'($urandom_range(64, 1));
      c   = 1'($urandom_range(1));
      val = {$urandom, $urandom};
      send_command(c, idx, len, val);
      sent++;
      // Read many writes straight back.
      if (c == pbfa_pkg::CMD_WRITE && $urandom_range(99) < 35) begin
        send_command(pbfa_pkg::CMD_READ, idx, len, {$urandom, $urandom});
        sent++;
      end
    end
  endtask

  // Reset, stimulus, drain and final verdict.
  initial begin
    int waited;
    store_model     = new();
    sender_calm     = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cmd          = pbfa_pkg::CMD_READ;
    in_bit_index    = '0;
    in_field_length = '0;
    in_write_value  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_valid <= 1'b0;
    waited = 0;
    while (store_model.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (store_model.pending() != 0) begin
      $error("%0d expected result words never arrived", store_model.pending());
      store_model.failures++;
    end
    if (store_model.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
src/pbfa_pkg.sv
src/pbfa_front.sv
src/pbfa_queue.sv
src/pbfa_back.sv
src/packed_bit_field_access.sv
verif/packed_bit_field_access_test.sv
